FILE: rtl/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg
// Function codes and control record shared by the vector arithmetic unit.
// ----------------------------------------------------------------------------
package v3a_pkg;

    typedef enum logic [2:0] {
        FN_ADD  = 3'd0,
        FN_SUB  = 3'd1,
        FN_MUL  = 3'd2,
        FN_DIV  = 3'd3,
        FN_EQ   = 3'd4,
        FN_MAG  = 3'd5,
        FN_NORM = 3'd6
    } t_func;

    typedef struct packed {
        t_func      fn;
        logic [2:0] a_neg;
        logic [2:0] b_neg;
        logic       eq;
        logic       flt;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

endpackage

FILE: rtl/v3a_front.sv
// ----------------------------------------------------------------------------
// v3a_front
// Request intake: decodes the function, splits components into sign and
// magnitude, and resolves add, sub and equal directly.
// ----------------------------------------------------------------------------
module v3a_front #(
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_func,
    input  logic [2:0][W-1:0]    i_a,
    input  logic [2:0][W-1:0]    i_b,
    output logic                 o_valid,
    input  logic                 i_ready,
    output v3a_pkg::t_ctl        o_ctl,
    output logic [2:0][W-1:0]    o_ma,
    output logic [2:0][W-1:0]    o_mb,
    output logic [2:0][W-1:0]    o_res
);
    import v3a_pkg::*;

    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

    logic             r_valid;
    t_ctl             r_ctl, n_ctl;
    logic [2:0][W-1:0] r_ma, n_ma, r_mb, n_mb, r_res, n_res;
    logic [W:0]       sum [0:2];

    always_comb begin
        n_ctl       = '0;
        n_ctl.fn    = t_func'(i_func);
        n_res       = '0;
        for (int k = 0; k < 3; k++) begin
            n_ctl.a_neg[k] = i_a[k][W-1];
            n_ctl.b_neg[k] = i_b[k][W-1];
            n_ma[k] = i_a[k][W-1] ? W'(-i_a[k]) : i_a[k];
            n_mb[k] = i_b[k][W-1] ? W'(-i_b[k]) : i_b[k];
            if (i_func == FN_SUB) begin
                sum[k] = {i_a[k][W-1], i_a[k]} - {i_b[k][W-1], i_b[k]};
            end else begin
                sum[k] = {i_a[k][W-1], i_a[k]} + {i_b[k][W-1], i_b[k]};
            end
            if (i_func == FN_ADD || i_func == FN_SUB) begin
                if (sum[k][W] != sum[k][W-1]) begin
                    n_res[k]  = sum[k][W] ? MINN : MAXP;
                    n_ctl.flt = 1'b1;
                end else begin
                    n_res[k] = sum[k][W-1:0];
                end
            end
        end
        n_ctl.eq = (i_func == FN_EQ) && (i_a == i_b);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl <= n_ctl;
            r_ma  <= n_ma;
            r_mb  <= n_mb;
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_ma    = r_ma;
    assign o_mb    = r_mb;
    assign o_res   = r_res;

endmodule

FILE: rtl/v3a_fifo.sv
// ----------------------------------------------------------------------------
// v3a_fifo
// Short queue between intake and the arithmetic pipeline. DEPTH is a power
// of two.
// ----------------------------------------------------------------------------
module v3a_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          push_ok, pop_ok;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push_ok) - (AW+1)'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/v3a_back.sv
// ----------------------------------------------------------------------------
// v3a_back
// Arithmetic pipeline: multiply, sum of squares, bit-per-stage square root,
// bit-per-stage divide, saturation and the output register.
// ----------------------------------------------------------------------------
module v3a_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_pop,
    input  v3a_pkg::t_ctl        i_ctl,
    input  logic [2:0][W-1:0]    i_ma,
    input  logic [2:0][W-1:0]    i_mb,
    input  logic [2:0][W-1:0]    i_res,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0][W-1:0]    o_r,
    output logic                 o_eq,
    output logic                 o_flt
);
    import v3a_pkg::*;

    localparam int QW = W + F;
    localparam int PW = (2*W > QW) ? 2*W : QW;
    localparam int RW = 2*W + 2;
    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W:0] pack_sat(input logic neg, input logic [PW-1:0] m);
        logic [W:0] r;
        if (!neg) begin
            r = (m > PW'(MAXP)) ? {1'b1, MAXP} : {1'b0, m[W-1:0]};
        end else begin
            r = (m > PW'(MINN)) ? {1'b1, MINN} : {1'b0, W'(-m[W-1:0])};
        end
        return r;
    endfunction

    logic en;
    logic r_ov;
    assign en    = !r_ov || i_ready;
    assign o_pop = en && i_valid;

    // multiply
    logic               r1_v;
    t_ctl               r1_ctl;
    logic [2:0][W-1:0]  r1_ma, r1_mb, r1_res;
    logic [2:0][2*W-1:0] r1_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ctl <= i_ctl;
            r1_ma  <= i_ma;
            r1_mb  <= i_mb;
            r1_res <= i_res;
            for (int k = 0; k < 3; k++) begin
                if (i_ctl.fn == FN_MAG || i_ctl.fn == FN_NORM) begin
                    r1_p[k] <= i_ma[k] * i_ma[k];
                end else begin
                    r1_p[k] <= i_ma[k] * i_mb[k];
                end
            end
        end
    end

    // product scaling and sum of squares
    logic               r2_v;
    t_ctl               r2_ctl, n2_ctl;
    logic [2:0][W-1:0]  r2_ma, r2_mb, r2_res, n2_res;
    logic [2*W-1:0]     r2_rad;
    logic [W:0]         mp [0:2];

    always_comb begin
        n2_ctl = r1_ctl;
        n2_res = r1_res;
        for (int k = 0; k < 3; k++) begin
            mp[k] = pack_sat(r1_ctl.a_neg[k] ^ r1_ctl.b_neg[k], PW'(r1_p[k] >> F));
            if (r1_ctl.fn == FN_MUL) begin
                n2_res[k]  = mp[k][W-1:0];
                n2_ctl.flt = n2_ctl.flt | mp[k][W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ctl <= n2_ctl;
            r2_ma  <= r1_ma;
            r2_mb  <= r1_mb;
            r2_res <= n2_res;
            r2_rad <= r1_p[0] + r1_p[1] + r1_p[2];
        end
    end

    // square root, one result bit per stage
    logic              sq_v    [0:W];
    t_ctl              sq_ctl  [0:W];
    logic [2:0][W-1:0] sq_ma   [0:W];
    logic [2:0][W-1:0] sq_mb   [0:W];
    logic [2:0][W-1:0] sq_res  [0:W];
    logic [2*W-1:0]    sq_rem  [0:W];
    logic [W-1:0]      sq_root [0:W];

    assign sq_v[0]    = r2_v;
    assign sq_ctl[0]  = r2_ctl;
    assign sq_ma[0]   = r2_ma;
    assign sq_mb[0]   = r2_mb;
    assign sq_res[0]  = r2_res;
    assign sq_rem[0]  = r2_rad;
    assign sq_root[0] = '0;

    for (genvar s = 0; s < W; s++) begin : g_sqrt
        localparam int B = W - 1 - s;
        logic [RW-1:0] t;
        logic          ge;

        assign t  = (RW'(sq_root[s]) << (B + 1)) | (RW'(1) << (2 * B));
        assign ge = RW'(sq_rem[s]) >= t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                sq_v[s+1] <= 1'b0;
            end else if (en) begin
                sq_v[s+1] <= sq_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                sq_ctl[s+1] <= sq_ctl[s];
                sq_ma[s+1]  <= sq_ma[s];
                sq_mb[s+1]  <= sq_mb[s];
                sq_res[s+1] <= sq_res[s];
                if (ge) begin
                    sq_rem[s+1]  <= sq_rem[s] - t[2*W-1:0];
                    sq_root[s+1] <= sq_root[s] | (W'(1) << B);
                end else begin
                    sq_rem[s+1]  <= sq_rem[s];
                    sq_root[s+1] <= sq_root[s];
                end
            end
        end
    end

    // divider setup and restoring divide, one quotient bit per stage
    logic               dv_v   [0:QW];
    t_ctl               dv_ctl [0:QW];
    logic [2:0][W-1:0]  dv_res [0:QW];
    logic [2:0]         dv_dz  [0:QW];
    logic [2:0][QW-1:0] dv_n   [0:QW];
    logic [2:0][W-1:0]  dv_d   [0:QW];
    logic [2:0][W-1:0]  dv_rem [0:QW];
    logic [2:0][QW-1:0] dv_q   [0:QW];

    t_ctl               su_ctl;
    logic [2:0][W-1:0]  su_res, su_d;
    logic [2:0]         su_dz;
    logic [2:0][QW-1:0] su_n;
    logic [W:0]         su_mag;

    always_comb begin
        su_ctl = sq_ctl[W];
        su_res = sq_res[W];
        su_mag = pack_sat(1'b0, PW'(sq_root[W]));
        for (int k = 0; k < 3; k++) begin
            su_n[k]  = QW'(sq_ma[W][k]) << F;
            su_d[k]  = (sq_ctl[W].fn == FN_DIV) ? sq_mb[W][k] : sq_root[W];
            su_dz[k] = (su_d[k] == '0);
            if (sq_ctl[W].fn == FN_DIV && su_dz[k]) begin
                su_flt_set: begin
                    su_ctl.flt = 1'b1;
                    if (sq_ma[W][k] == '0) begin
                        su_res[k] = '0;
                    end else begin
                        su_res[k] = sq_ctl[W].a_neg[k] ? MINN : MAXP;
                    end
                end
            end
        end
        case (sq_ctl[W].fn)
            FN_MAG: begin
                su_res[0]  = su_mag[W-1:0];
                su_ctl.flt = su_mag[W];
            end
            FN_NORM: begin
                if (sq_root[W] == '0) begin
                    su_ctl.flt = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            dv_v[0] <= 1'b0;
        end else if (en) begin
            dv_v[0] <= sq_v[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            dv_ctl[0] <= su_ctl;
            dv_res[0] <= su_res;
            dv_dz[0]  <= su_dz;
            dv_n[0]   <= su_n;
            dv_d[0]   <= su_d;
            dv_rem[0] <= '0;
            dv_q[0]   <= '0;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int B = QW - 1 - s;
        logic [2:0][W:0]   rs;
        logic [2:0]        ge;
        logic [2:0][W-1:0] nrem;
        logic [2:0][QW-1:0] nq;

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                rs[k]    = {dv_rem[s][k], dv_n[s][k][B]};
                ge[k]    = rs[k] >= {1'b0, dv_d[s][k]};
                nrem[k]  = ge[k] ? W'(rs[k] - {1'b0, dv_d[s][k]}) : rs[k][W-1:0];
                nq[k]    = dv_q[s][k] | (QW'(ge[k]) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                dv_v[s+1] <= 1'b0;
            end else if (en) begin
                dv_v[s+1] <= dv_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                dv_ctl[s+1] <= dv_ctl[s];
                dv_res[s+1] <= dv_res[s];
                dv_dz[s+1]  <= dv_dz[s];
                dv_n[s+1]   <= dv_n[s];
                dv_d[s+1]   <= dv_d[s];
                dv_rem[s+1] <= nrem;
                dv_q[s+1]   <= nq;
            end
        end
    end

    // saturation and output register
    t_ctl              fo_ctl;
    logic [2:0][W-1:0] fo_res;
    logic [W:0]        qp [0:2];
    logic [2:0][W-1:0] r_or;
    logic              r_oeq, r_oflt;

    always_comb begin
        fo_ctl = dv_ctl[QW];
        fo_res = dv_res[QW];
        for (int k = 0; k < 3; k++) begin
            if (dv_ctl[QW].fn == FN_DIV) begin
                qp[k] = pack_sat(dv_ctl[QW].a_neg[k] ^ dv_ctl[QW].b_neg[k],
                                 PW'(dv_q[QW][k]));
            end else begin
                qp[k] = pack_sat(dv_ctl[QW].a_neg[k], PW'(dv_q[QW][k]));
            end
            if ((dv_ctl[QW].fn == FN_DIV || dv_ctl[QW].fn == FN_NORM) && !dv_dz[QW][k]) begin
                fo_res[k]  = qp[k][W-1:0];
                fo_ctl.flt = fo_ctl.flt | qp[k][W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_or   <= fo_res;
            r_oeq  <= fo_ctl.eq;
            r_oflt <= fo_ctl.flt;
        end
    end

    assign o_valid = r_ov;
    assign o_r     = r_or;
    assign o_eq    = r_oeq;
    assign o_flt   = r_oflt;

endmodule

FILE: rtl/vector3_arith_unit.sv
// ----------------------------------------------------------------------------
// vector3_arith_unit
// Three-component vector add, sub, mul, div, equal, magnitude and normalize
// in signed fixed point with saturation.
// ----------------------------------------------------------------------------
// One request per clock is accepted and one result per clock is delivered
// while the result side is not held. Every request passes through the square
// root stages (one root bit per stage) followed by the divider stages (one
// quotient bit per stage); a four-entry queue after the intake keeps
// requests flowing while the result side is held.
module vector3_arith_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [((6*DATA_WIDTH+7)/8)*8-1:0]    i_s_tdata,  // ax, ay, az, bx, by, bz
    input  logic [2:0]                           i_s_tuser,  // func
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0]    o_m_tdata,  // rx, ry, rz
    output logic [1:0]                           o_m_tuser   // equal, fault
);
    import v3a_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int ODW = ((3*W+7)/8)*8;
    localparam int PLW = CTL_W + 9*W;

    logic [2:0][W-1:0] a, b;

    for (genvar k = 0; k < 3; k++) begin : g_unpack
        assign a[k] = i_s_tdata[k*W +: W];
        assign b[k] = i_s_tdata[(k+3)*W +: W];
    end

    logic              fr_valid, fq_full, fq_valid, bk_pop, bk_eq, bk_flt;
    t_ctl              fr_ctl, fq_ctl;
    logic [2:0][W-1:0] fr_ma, fr_mb, fr_res, fq_ma, fq_mb, fq_res, bk_r;
    logic [PLW-1:0]    fq_data;

    v3a_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_func  (i_s_tuser),
        .i_a     (a),
        .i_b     (b),
        .o_valid (fr_valid),
        .i_ready (!fq_full),
        .o_ctl   (fr_ctl),
        .o_ma    (fr_ma),
        .o_mb    (fr_mb),
        .o_res   (fr_res)
    );

    v3a_fifo #(.DW(PLW), .DEPTH(4)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_data  ({fr_ctl, fr_res, fr_mb, fr_ma}),
        .o_full  (fq_full),
        .i_pop   (bk_pop),
        .o_valid (fq_valid),
        .o_data  (fq_data)
    );

    assign {fq_ctl, fq_res, fq_mb, fq_ma} = fq_data;

    v3a_back #(.W(W), .F(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_pop   (bk_pop),
        .i_ctl   (fq_ctl),
        .i_ma    (fq_ma),
        .i_mb    (fq_mb),
        .i_res   (fq_res),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_r     (bk_r),
        .o_eq    (bk_eq),
        .o_flt   (bk_flt)
    );

    assign o_m_tdata = ODW'(bk_r);
    assign o_m_tuser = {bk_flt, bk_eq};

endmodule

FILE: dv/tb_vector3_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector3_arith_unit
// Self-checking bench for the vector arithmetic unit: directed corner requests,
// then ~1100 random requests under varying source and sink throttling, each
// result checked field by field against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_vector3_arith_unit;
    import v3a_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam logic [2:0] FN_SPARE = 3'd7;
    localparam logic [DW-1:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] MINN = 32'h8000_0000;
    localparam int N_RAND = 1100;
    localparam int DRAIN_AT = 600;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [2:0]    fn;
        logic [DW-1:0] a [3];
        logic [DW-1:0] b [3];
    } t_req;

    typedef struct {
        logic [DW-1:0] r [3];
        logic          eq;
        logic          flt;
    } t_res;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_s_tvalid;
    logic            o_s_tready;
    logic [191:0]    i_s_tdata;  // ax, ay, az, bx, by, bz
    logic [2:0]      i_s_tuser;  // func
    logic            o_m_tvalid;
    logic            i_m_tready;
    logic [95:0]     o_m_tdata;  // rx, ry, rz
    logic [1:0]      o_m_tuser;  // equal, fault

    vector3_arith_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (.*);

    t_req req_q [$];
    t_res result_q [$];
    t_req cur_req;
    int   n_accepted;
    int   n_results;
    int   n_errors;
    int   n_cycles;
    int   src_idle;
    int   snk_idle;
    bit   stim_done;
    int   fn_hits [8];

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // ---------------- predictor ----------------
    function automatic logic [DW-1:0] sat_pack(bit neg, logic [127:0] m, inout bit flt);
        if (!neg) begin
            if (m > 128'(MAXP)) begin flt = 1; return MAXP; end
            return m[DW-1:0];
        end
        if (m > 128'(MINN)) begin flt = 1; return MINN; end
        return DW'(-m[DW:0]);
    endfunction

    function automatic logic [127:0] abs_val(logic [DW-1:0] x);
        longint v;
        v = longint'($signed(x));
        return 128'(v < 0 ? -v : v);
    endfunction

    function automatic logic [DW-1:0] add_sub(logic [DW-1:0] a, logic [DW-1:0] b,
                                              bit sub, inout bit flt);
        longint s;
        s = sub ? longint'($signed(a)) - longint'($signed(b))
                : longint'($signed(a)) + longint'($signed(b));
        if (s > 64'sd2147483647) begin flt = 1; return MAXP; end
        if (s < -64'sd2147483648) begin flt = 1; return MINN; end
        return s[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] quot(logic [DW-1:0] a, logic [127:0] mb,
                                           bit bneg, inout bit flt);
        logic [127:0] ma;
        ma = abs_val(a);
        if (mb == 0) begin
            flt = 1;
            if (ma == 0) return '0;
            return a[DW-1] ? MINN : MAXP;
        end
        return sat_pack(a[DW-1] ^ bneg, (ma << FB) / mb, flt);
    endfunction

    function automatic logic [127:0] int_sqrt(logic [127:0] n);
        logic [127:0] res, t;
        res = 0;
        for (int i = 40; i >= 0; i--) begin
            t = res | (128'd1 << i);
            if (t * t <= n) res = t;
        end
        return res;
    endfunction

    function automatic t_res vec_compute(t_req q);
        t_res o;
        bit flt;
        logic [127:0] len, m;
        flt = 0;
        o.eq = 0;
        o.r = '{default: '0};
        case (q.fn)
            FN_ADD, FN_SUB:
                for (int i = 0; i < 3; i++) o.r[i] = add_sub(q.a[i], q.b[i], q.fn == FN_SUB, flt);
            FN_MUL:
                for (int i = 0; i < 3; i++)
                    o.r[i] = sat_pack(q.a[i][DW-1] ^ q.b[i][DW-1],
                                      (abs_val(q.a[i]) * abs_val(q.b[i])) >> FB, flt);
            FN_DIV:
                for (int i = 0; i < 3; i++)
                    o.r[i] = quot(q.a[i], abs_val(q.b[i]), q.b[i][DW-1], flt);
            FN_EQ:
                o.eq = (q.a[0] == q.b[0]) && (q.a[1] == q.b[1]) && (q.a[2] == q.b[2]);
            FN_MAG, FN_NORM: begin
                len = 0;
                for (int i = 0; i < 3; i++) begin
                    m = abs_val(q.a[i]);
                    len += m * m;
                end
                len = int_sqrt(len);
                if (q.fn == FN_MAG) o.r[0] = sat_pack(0, len, flt);
                else if (len == 0) flt = 1;
                else for (int i = 0; i < 3; i++) o.r[i] = quot(q.a[i], len, 0, flt);
            end
            default: ;
        endcase
        o.flt = flt;
        return o;
    endfunction

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_idle);
            if (i_s_tvalid && o_s_tready) begin
                result_q.push_back(vec_compute(cur_req));
                fn_hits[cur_req.fn]++;
                n_accepted++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (req_q.size() > 0 && !(n_accepted == DRAIN_AT && result_q.size() != 0)
                        && $urandom_range(99) >= src_idle) begin
                    cur_req = req_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser <= cur_req.fn;
                    i_s_tdata <= {cur_req.b[2], cur_req.b[1], cur_req.b[0],
                                  cur_req.a[2], cur_req.a[1], cur_req.a[0]};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // throttle phases follow progress
    always @(posedge i_clk) begin
        if (n_accepted < 20 + N_RAND / 3) begin
            src_idle <= 38; snk_idle <= 45;
        end else if (n_accepted < 20 + 2 * N_RAND / 3) begin
            src_idle <= 45; snk_idle <= 38;
        end else begin
            src_idle <= 0; snk_idle <= 0;
        end
    end

    // ---------------- monitor ----------------
    task automatic report(string what, logic [DW-1:0] want, logic [DW-1:0] got);
        $display("mismatch on result %0d: %s expected %h got %h", n_results, what, want, got);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (result_q.size() == 0) begin
                $display("unexpected result %h / %h", o_m_tdata, o_m_tuser);
                n_errors++;
            end else begin
                w = result_q.pop_front();
                if (o_m_tdata[31:0] !== w.r[0]) report("rx", w.r[0], o_m_tdata[31:0]);
                if (o_m_tdata[63:32] !== w.r[1]) report("ry", w.r[1], o_m_tdata[63:32]);
                if (o_m_tdata[95:64] !== w.r[2]) report("rz", w.r[2], o_m_tdata[95:64]);
                if (o_m_tuser[0] !== w.eq) report("equal", w.eq, o_m_tuser[0]);
                if (o_m_tuser[1] !== w.flt) report("fault", w.flt, o_m_tuser[1]);
            end
            n_results++;
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout: %0d results outstanding", result_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [DW-1:0] rand_comp();
        logic [DW-1:0] pick [5] = '{32'h0, 32'h1, 32'hFFFF_FFFF, MAXP, MINN};
        case ($urandom_range(7))
            0, 1: return $urandom;
            2:    return pick[$urandom_range(4)];
            3:    return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return DW'($signed($urandom) >>> $urandom_range(24, 4));
        endcase
    endfunction

    task automatic add_req(logic [2:0] fn, logic [DW-1:0] ax, logic [DW-1:0] ay,
                           logic [DW-1:0] az, logic [DW-1:0] bx, logic [DW-1:0] by,
                           logic [DW-1:0] bz);
        t_req q;
        q.fn = fn;
        q.a = '{ax, ay, az};
        q.b = '{bx, by, bz};
        req_q.push_back(q);
    endtask

    initial begin
        t_req q;
        n_accepted = 0; n_results = 0; n_errors = 0; n_cycles = 0;
        src_idle = 38; snk_idle = 45;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 1'b0;
        // directed corners
        add_req(FN_ADD, MAXP, MINN, 32'h0001_0000, 32'h1, 32'hFFFF_FFFF, 32'h0002_0000);
        add_req(FN_ADD, MINN, MAXP, 0, MINN, MAXP, 0);
        add_req(FN_SUB, MINN, MAXP, 32'h0003_0000, 32'h1, MINN, 32'h0001_8000);
        add_req(FN_SUB, MAXP, 0, MINN, MINN, MINN, MAXP);
        add_req(FN_MUL, MAXP, MINN, 32'h0002_0000, MAXP, MINN, 32'hFFFE_8000);
        add_req(FN_MUL, 32'h0000_8000, 32'hFFFF_FFFF, 0, 32'h0000_8000, 32'h1, MINN);
        add_req(FN_DIV, 32'h0001_0000, MINN, 0, 0, 0, 0);
        add_req(FN_DIV, MAXP, MINN, 32'h0003_0000, 32'h1, 32'hFFFF_FFFF, 32'h0002_0000);
        add_req(FN_DIV, MINN, 32'h0000_0001, 32'hFFFF_0000, MAXP, MINN, 32'hFFFF_FFFF);
        add_req(FN_EQ, 32'h1234_5678, MINN, MAXP, 32'h1234_5678, MINN, MAXP);
        add_req(FN_EQ, 32'h1234_5678, MINN, MAXP, 32'h1234_5678, MINN, 32'h7FFF_FFFE);
        add_req(FN_MAG, MINN, MINN, MINN, 0, 0, 0);
        add_req(FN_MAG, 32'h0003_0000, 32'h0004_0000, 0, MAXP, 1, 2);
        add_req(FN_MAG, 0, 0, 0, 0, 0, 0);
        add_req(FN_NORM, 0, 0, 0, MAXP, MINN, 1);
        add_req(FN_NORM, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0, 0);
        add_req(FN_NORM, MINN, MAXP, 1, 0, 0, 0);
        add_req(FN_NORM, 32'h1, 0, 0, 0, 0, 0);
        add_req(FN_SPARE, MAXP, MINN, 32'hFFFF_FFFF, MINN, MAXP, 32'h1);
        add_req(FN_SPARE, 0, 0, 0, 0, 0, 0);
        for (int n = 0; n < N_RAND; n++) begin
            q.fn = $urandom_range(7);
            for (int i = 0; i < 3; i++) begin
                q.a[i] = rand_comp();
                q.b[i] = rand_comp();
            end
            if (q.fn == FN_EQ && $urandom_range(1)) begin
                q.b = q.a;
                if ($urandom_range(1)) q.b[$urandom_range(2)] ^= 32'h1 << $urandom_range(31);
            end
            if (q.fn == FN_DIV && $urandom_range(3) == 0) q.b[$urandom_range(2)] = 0;
            req_q.push_back(q);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (req_q.size() == 0 && !i_s_tvalid && result_q.size() == 0);
        repeat (250) @(posedge i_clk);
        $display("%0d requests, %0d results; add %0d sub %0d mul %0d div %0d eq %0d",
                 n_accepted, n_results, fn_hits[0], fn_hits[1], fn_hits[2], fn_hits[3],
                 fn_hits[4]);
        $display("mag %0d norm %0d spare %0d; throttled both ways and unthrottled",
                 fn_hits[5], fn_hits[6], fn_hits[7]);
        if (n_errors == 0 && result_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
